// File: hw/rtl/dmix_pkg.sv
package dmix_pkg;

    // Field and datapath widths.
    localparam int FUNC_W  = 4;
    localparam int SPEED_W = 17;
    localparam int CFG_W   = 15;
    localparam int IDX_W   = 2;
    localparam int MAG_W   = 18;
    localparam int SUM_W   = 19;
    localparam int Q_W     = 15;
    localparam int OUT_W   = 16;

    // Register values after reset.
    localparam logic [CFG_W-1:0] MAX_VEL_RST  = 15'd200;
    localparam logic [CFG_W-1:0] MAX_VOLT_RST = 15'd12000;
    localparam logic [CFG_W-1:0] DEADBAND_RST = 15'd0;

    // Drive modes carried in the input selector.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_STOP     = 4'd0,
        FUNC_FORWARD  = 4'd1,
        FUNC_ROTATE   = 4'd2,
        FUNC_VEC_VEL  = 4'd3,
        FUNC_VEC_VOLT = 4'd4,
        FUNC_TANK     = 4'd5,
        FUNC_ARCADE   = 4'd6,
        FUNC_LEFT     = 4'd7,
        FUNC_RIGHT    = 4'd8
    } t_func;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_MAX_VEL  = 2'd0,
        CFG_MAX_VOLT = 2'd1,
        CFG_DEADBAND = 2'd2
    } t_cfg_idx;

    // Per-item flags that travel beside the magnitudes.
    typedef struct packed {
        logic lval;
        logic rval;
        logic volt;
        logic lneg;
        logic rneg;
    } t_side;

endpackage

// File: hw/rtl/dmix_mix.sv
module dmix_mix
    import dmix_pkg::*;
#(
    parameter int FRAC_BITS = 14,
    parameter int DEN_W     = 18
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic signed [SPEED_W-1:0] i_speed_a,
    input  logic signed [SPEED_W-1:0] i_speed_b,
    input  logic [CFG_W-1:0]          i_max_velocity,
    input  logic [CFG_W-1:0]          i_max_voltage,
    input  logic [CFG_W-1:0]          i_deadband,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [MAG_W-1:0]          o_l_mag,
    output logic [MAG_W-1:0]          o_r_mag,
    output logic [DEN_W-1:0]          o_den,
    output logic [CFG_W-1:0]          o_full,
    output t_side                     o_side
);

    localparam int CLAMP_W = (FRAC_BITS + 2 > SUM_W) ? FRAC_BITS + 2 : SUM_W;
    localparam logic signed [CLAMP_W-1:0] ONE_C = CLAMP_W'(1) << FRAC_BITS;

    function automatic logic signed [CLAMP_W-1:0] f_clamp(
        input logic signed [CLAMP_W-1:0] x
    );
        if (x > ONE_C) begin
            return ONE_C;
        end else if (x < -ONE_C) begin
            return -ONE_C;
        end
        return x;
    endfunction

    function automatic logic [MAG_W-1:0] f_abs(input logic signed [MAG_W-1:0] x);
        logic signed [MAG_W-1:0] n;
        n = -x;
        return x[MAG_W-1] ? n : x;
    endfunction

    logic                     en;
    logic                     r_v1, r_v2, r_v3, r_v4;

    logic [FUNC_W-1:0]        r_func1, r_func2;
    logic signed [MAG_W-1:0]  r_a1, r_b1, r_a2, r_b2;
    logic signed [SUM_W-1:0]  r_l3, r_r3;
    logic                     r_vec3;
    t_side                    r_side3;
    logic [MAG_W-1:0]         r_l_mag4, r_r_mag4;
    logic [DEN_W-1:0]         r_den4;
    logic [CFG_W-1:0]         r_full4;
    t_side                    r_side4;

    logic signed [CLAMP_W-1:0] w_a_clp, w_b_clp;
    logic signed [MAG_W-1:0]   n_a2, n_b2;
    logic [MAG_W-1:0]          w_a1_abs, w_b1_abs, w_db;
    logic signed [SUM_W-1:0]   n_l3, n_r3, w_a3, w_b3, w_mx;
    logic [MAG_W-1:0]          w_a2_abs, w_b2_abs, w_mx_mag;
    logic                      n_vec3;
    t_side                     n_side3;
    logic signed [CLAMP_W-1:0] w_l4, w_r4, w_l4_abs, w_r4_abs;
    logic [MAG_W-1:0]          n_l_mag4, n_r_mag4, w_m4;
    logic [DEN_W-1:0]          n_den4;
    t_side                     n_side4;

    // The whole front moves together unless its last stage is held.
    assign en      = !r_v4 || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stage 1: clamp both speeds to plus or minus one.
    assign w_a_clp = f_clamp(CLAMP_W'(i_speed_a));
    assign w_b_clp = f_clamp(CLAMP_W'(i_speed_b));

    // Stage 2: deadband, strict for tank and inclusive for arcade.
    always_comb begin
        w_a1_abs = f_abs(r_a1);
        w_b1_abs = f_abs(r_b1);
        w_db     = MAG_W'(i_deadband);
        n_a2     = r_a1;
        n_b2     = r_b1;
        case (r_func1)
            FUNC_TANK: begin
                if (w_a1_abs < w_db) n_a2 = '0;
                if (w_b1_abs < w_db) n_b2 = '0;
            end
            FUNC_ARCADE: begin
                if (w_a1_abs <= w_db) n_a2 = '0;
                if (w_b1_abs <= w_db) n_b2 = '0;
            end
            default: begin
            end
        endcase
    end

    // Stage 3: form the left and right side commands for each mode.
    always_comb begin
        w_a3     = SUM_W'(r_a2);
        w_b3     = SUM_W'(r_b2);
        w_a2_abs = f_abs(r_a2);
        w_b2_abs = f_abs(r_b2);
        w_mx_mag = (w_a2_abs > w_b2_abs) ? w_a2_abs : w_b2_abs;
        w_mx     = r_a2[MAG_W-1] ? -$signed(SUM_W'(w_mx_mag)) : $signed(SUM_W'(w_mx_mag));
        n_l3     = '0;
        n_r3     = '0;
        n_vec3   = 1'b0;
        n_side3  = '{lval: 1'b1, rval: 1'b1, volt: 1'b0, lneg: 1'b0, rneg: 1'b0};
        unique case (r_func2)
            FUNC_STOP: begin
            end
            FUNC_FORWARD: begin
                n_l3 = w_a3;
                n_r3 = w_a3;
            end
            FUNC_ROTATE: begin
                n_l3 = w_a3;
                n_r3 = -w_a3;
            end
            FUNC_VEC_VEL: begin
                n_l3   = w_a3 + w_b3;
                n_r3   = w_a3 - w_b3;
                n_vec3 = 1'b1;
            end
            FUNC_VEC_VOLT: begin
                n_l3         = w_a3 + w_b3;
                n_r3         = w_a3 - w_b3;
                n_vec3       = 1'b1;
                n_side3.volt = 1'b1;
            end
            FUNC_TANK: begin
                n_l3         = w_a3;
                n_r3         = w_b3;
                n_side3.volt = 1'b1;
            end
            FUNC_ARCADE: begin
                n_side3.volt = 1'b1;
                if (r_a2[MAG_W-1] == r_b2[MAG_W-1]) begin
                    n_l3 = w_mx;
                    n_r3 = w_a3 - w_b3;
                end else begin
                    n_l3 = w_a3 + w_b3;
                    n_r3 = w_mx;
                end
            end
            FUNC_LEFT: begin
                n_l3         = w_a3;
                n_side3.rval = 1'b0;
            end
            FUNC_RIGHT: begin
                n_r3         = w_a3;
                n_side3.lval = 1'b0;
            end
            default: begin
                n_side3.lval = 1'b0;
                n_side3.rval = 1'b0;
            end
        endcase
    end

    // Stage 4: clamp outside vector mode, split sign and magnitude, pick the divisor.
    always_comb begin
        w_l4 = CLAMP_W'(r_l3);
        w_r4 = CLAMP_W'(r_r3);
        if (!r_vec3) begin
            w_l4 = f_clamp(w_l4);
            w_r4 = f_clamp(w_r4);
        end
        w_l4_abs = w_l4[CLAMP_W-1] ? -w_l4 : w_l4;
        w_r4_abs = w_r4[CLAMP_W-1] ? -w_r4 : w_r4;
        n_l_mag4 = w_l4_abs[MAG_W-1:0];
        n_r_mag4 = w_r4_abs[MAG_W-1:0];
        w_m4     = (n_l_mag4 > n_r_mag4) ? n_l_mag4 : n_r_mag4;
        if (r_vec3 && ($signed(CLAMP_W'(w_m4)) > ONE_C)) begin
            n_den4 = DEN_W'(w_m4);
        end else begin
            n_den4 = ONE_C[DEN_W-1:0];
        end
        n_side4      = r_side3;
        n_side4.lneg = r_l3[SUM_W-1];
        n_side4.rneg = r_r3[SUM_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_func1  <= i_func;
            r_a1     <= w_a_clp[MAG_W-1:0];
            r_b1     <= w_b_clp[MAG_W-1:0];
            r_func2  <= r_func1;
            r_a2     <= n_a2;
            r_b2     <= n_b2;
            r_l3     <= n_l3;
            r_r3     <= n_r3;
            r_vec3   <= n_vec3;
            r_side3  <= n_side3;
            r_l_mag4 <= n_l_mag4;
            r_r_mag4 <= n_r_mag4;
            r_den4   <= n_den4;
            r_full4  <= r_side3.volt ? i_max_voltage : i_max_velocity;
            r_side4  <= n_side4;
        end
    end

    assign o_valid = r_v4;
    assign o_l_mag = r_l_mag4;
    assign o_r_mag = r_r_mag4;
    assign o_den   = r_den4;
    assign o_full  = r_full4;
    assign o_side  = r_side4;

endmodule

// File: hw/rtl/dmix_div.sv
module dmix_div
    import dmix_pkg::*;
#(
    parameter int DEN_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [MAG_W-1:0] i_l_mag,
    input  logic [MAG_W-1:0] i_r_mag,
    input  logic [DEN_W-1:0] i_den,
    input  logic [CFG_W-1:0] i_full,
    input  t_side            i_side,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [Q_W-1:0]   o_l_q,
    output logic [Q_W-1:0]   o_r_q,
    output t_side            o_side
);

    localparam int NUM_W = MAG_W + CFG_W;
    localparam int REM_W = DEN_W + Q_W;

    logic                 en;
    logic                 r_v    [0:Q_W];
    logic [REM_W-1:0]     r_rem  [0:Q_W-1][0:1];
    logic [DEN_W-1:0]     r_den  [0:Q_W-1];
    logic [Q_W-1:0]       r_q    [0:Q_W][0:1];
    t_side                r_side [0:Q_W];

    logic [NUM_W-1:0]     w_prod [0:1];
    logic [REM_W-1:0]     w_dsh  [0:Q_W-1];
    logic                 w_ge   [0:Q_W-1][0:1];
    logic [REM_W-1:0]     n_rem  [0:Q_W-2][0:1];
    logic [Q_W-1:0]       n_q    [0:Q_W-1][0:1];

    assign en      = !r_v[Q_W] || i_ready;
    assign o_ready = en;

    // Numerators: side magnitude times the full-scale register.
    assign w_prod[0] = NUM_W'(i_l_mag) * NUM_W'(i_full);
    assign w_prod[1] = NUM_W'(i_r_mag) * NUM_W'(i_full);

    // Restoring division, one quotient bit per stage, both sides in parallel.
    always_comb begin
        for (int s = 0; s < Q_W; s++) begin
            w_dsh[s] = REM_W'(r_den[s]) << (Q_W - 1 - s);
            for (int j = 0; j < 2; j++) begin
                w_ge[s][j] = r_rem[s][j] >= w_dsh[s];
                n_q[s][j]  = r_q[s][j];
                n_q[s][j][Q_W-1-s] = w_ge[s][j];
            end
        end
        for (int s = 0; s < Q_W - 1; s++) begin
            for (int j = 0; j < 2; j++) begin
                n_rem[s][j] = w_ge[s][j] ? (r_rem[s][j] - w_dsh[s]) : r_rem[s][j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= Q_W; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= Q_W; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int j = 0; j < 2; j++) begin
                r_rem[0][j] <= REM_W'(w_prod[j]);
                r_q[0][j]   <= '0;
            end
            for (int s = 1; s < Q_W; s++) begin
                r_den[s] <= r_den[s-1];
                for (int j = 0; j < 2; j++) begin
                    r_rem[s][j] <= n_rem[s-1][j];
                end
            end
            for (int s = 1; s <= Q_W; s++) begin
                r_side[s] <= r_side[s-1];
                for (int j = 0; j < 2; j++) begin
                    r_q[s][j] <= n_q[s-1][j];
                end
            end
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_l_q   = r_q[Q_W][0];
    assign o_r_q   = r_q[Q_W][1];
    assign o_side  = r_side[Q_W];

endmodule

// File: hw/rtl/differential_drive_mixer.sv
// Skid-steer drive mixer. Each input transaction carries a drive mode in
// s_axis_tuser and two signed Q3.14 speeds in s_axis_tdata; each produces
// exactly one output transaction with the left and right motor commands,
// scaled by max_velocity or max_voltage and truncated toward zero. The block
// takes one transaction per clock unless backpressure holds it. A result
// passes through the clamping, deadband and mixing front end, the multiply,
// the one-bit-per-stage divider that normalizes vector drive, and the output
// register. Backpressure holds each section of the pipeline, the front end
// and the divider, as a whole once its last stage is full, so a result
// waiting at the output stops the input as soon as those stages fill.
// Registers are written through the i_cfg port, which is always ready.
module differential_drive_mixer
    import dmix_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,   // speed_a[16:0], speed_b[33:17], zero pad
    input  logic [FUNC_W-1:0]     s_axis_tuser,   // func[3:0]
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [2*OUT_W-1:0]    m_axis_tdata,   // left_value[15:0], right_value[31:16]
    output logic [2:0]            m_axis_tuser,   // left_valid[0], right_valid[1], is_voltage[2]
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int DEN_W = (FRAC_BITS + 1 > MAG_W) ? FRAC_BITS + 1 : MAG_W;

    logic [CFG_W-1:0]  r_max_velocity, r_max_voltage, r_deadband;

    logic              mix_ready, mix_valid;
    logic [MAG_W-1:0]  mix_l_mag, mix_r_mag;
    logic [DEN_W-1:0]  mix_den;
    logic [CFG_W-1:0]  mix_full;
    t_side             mix_side;

    logic              div_ready, div_valid;
    logic [Q_W-1:0]    div_l_q, div_r_q;
    t_side             div_side;

    logic              out_ready;
    logic              r_m_tvalid;
    logic [2*OUT_W-1:0] r_m_tdata;
    logic [2:0]        r_m_tuser;
    logic [OUT_W-1:0]  n_left, n_right;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_velocity <= MAX_VEL_RST;
            r_max_voltage  <= MAX_VOLT_RST;
            r_deadband     <= DEADBAND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_VEL:  r_max_velocity <= i_cfg_data;
                CFG_MAX_VOLT: r_max_voltage  <= i_cfg_data;
                CFG_DEADBAND: r_deadband     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp, deadband and mixing front end.
    dmix_mix #(
        .FRAC_BITS (FRAC_BITS),
        .DEN_W     (DEN_W)
    ) u_mix (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (mix_ready),
        .i_func         (s_axis_tuser),
        .i_speed_a      (s_axis_tdata[SPEED_W-1:0]),
        .i_speed_b      (s_axis_tdata[2*SPEED_W-1:SPEED_W]),
        .i_max_velocity (r_max_velocity),
        .i_max_voltage  (r_max_voltage),
        .i_deadband     (r_deadband),
        .o_valid        (mix_valid),
        .i_ready        (div_ready),
        .o_l_mag        (mix_l_mag),
        .o_r_mag        (mix_r_mag),
        .o_den          (mix_den),
        .o_full         (mix_full),
        .o_side         (mix_side)
    );

    assign s_axis_tready = mix_ready;

    // Scaling: multiply by full scale, then divide by the normalizer.
    dmix_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mix_valid),
        .o_ready (div_ready),
        .i_l_mag (mix_l_mag),
        .i_r_mag (mix_r_mag),
        .i_den   (mix_den),
        .i_full  (mix_full),
        .i_side  (mix_side),
        .o_valid (div_valid),
        .i_ready (out_ready),
        .o_l_q   (div_l_q),
        .o_r_q   (div_r_q),
        .o_side  (div_side)
    );

    // Output register: restore the signs and pack the transaction.
    assign out_ready = !r_m_tvalid || m_axis_tready;
    assign n_left    = div_side.lneg ? -OUT_W'(div_l_q) : OUT_W'(div_l_q);
    assign n_right   = div_side.rneg ? -OUT_W'(div_r_q) : OUT_W'(div_r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_ready) begin
            r_m_tvalid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_m_tdata <= {n_right, n_left};
            r_m_tuser <= {div_side.volt, div_side.rval, div_side.lval};
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

endmodule

// File: hw/rtl/dmix_checker.sv
module dmix_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // A side that is not commanded always reads zero.
    a_idle_side_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tdata[15:0] == 16'h0000) &&
                          (m_axis_tuser[1] || m_axis_tdata[31:16] == 16'h0000))
        else $error("uncommanded side carries a nonzero value");

    // Voltage commands always drive both motors.
    a_volt_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[0] && m_axis_tuser[1])
        else $error("voltage command without both sides");

    // Scaled magnitudes never exceed full scale, so the most negative code never appears.
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000 && m_axis_tdata[31:16] != 16'h8000)
        else $error("motor command wrapped");

    // A stalled output transaction holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

endmodule

bind differential_drive_mixer dmix_checker u_dmix_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: dv/drive_mix_checker.sv
`timescale 1ns / 100ps

// Watches the stream and register channels of the drive mixer, predicts the
// motor commands of every accepted input transaction and compares them, in
// order, with the output transactions.
module drive_mix_checker
    import dmix_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [39:0]        s_axis_tdata,
    input  logic [FUNC_W-1:0]  s_axis_tuser,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [2*OUT_W-1:0] m_axis_tdata,
    input  logic [2:0]         m_axis_tuser,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output int                 o_pending,
    output int                 o_fail_count
);

    localparam int     FRAC = 14;
    localparam longint UNIT = longint'(1) << FRAC;
    localparam int     REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_value;
        logic signed [OUT_W-1:0] right_value;
        logic                    left_valid;
        logic                    right_valid;
        logic                    is_voltage;
    } motor_cmd_t;

    // Shadow copies of the registers and the commands still owed by the block.
    logic [CFG_W-1:0] max_vel;
    logic [CFG_W-1:0] max_volt;
    logic [CFG_W-1:0] deadband;
    motor_cmd_t       motor_cmd_queue[$];
    int               fail_count = 0;

    function automatic longint mag(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint clip_unit(input longint x);
        if (x > UNIT) return UNIT;
        if (x < -UNIT) return -UNIT;
        return x;
    endfunction

    // Scales a side by full / den and truncates toward zero.
    function automatic logic signed [OUT_W-1:0] scale_cmd(input longint x, input longint full,
                                                          input longint den);
        longint q;
        q = (mag(x) * full) / den;
        if (x < 0) q = -q;
        return q[OUT_W-1:0];
    endfunction

    // Mixes one clamped speed pair into left and right motor commands.
    function automatic motor_cmd_t mix_motor_cmds(input logic [FUNC_W-1:0] func,
                                                  input logic signed [SPEED_W-1:0] raw_a,
                                                  input logic signed [SPEED_W-1:0] raw_b);
        motor_cmd_t cmd;
        longint a, b, l, r, m, den, mx, full, dz;
        a = clip_unit(longint'(raw_a));
        b = clip_unit(longint'(raw_b));
        dz = longint'(deadband);
        cmd = '0;
        cmd.left_valid = 1'b1;
        cmd.right_valid = 1'b1;
        case (func)
            FUNC_STOP: begin
            end
            FUNC_FORWARD: begin
                cmd.left_value = scale_cmd(a, max_vel, UNIT);
                cmd.right_value = cmd.left_value;
            end
            FUNC_ROTATE: begin
                cmd.left_value = scale_cmd(a, max_vel, UNIT);
                cmd.right_value = -cmd.left_value;
            end
            FUNC_VEC_VEL, FUNC_VEC_VOLT: begin
                // Normalize by the larger side once it exceeds full scale.
                full = (func == FUNC_VEC_VEL) ? longint'(max_vel) : longint'(max_volt);
                l = a + b;
                r = a - b;
                m = (mag(l) > mag(r)) ? mag(l) : mag(r);
                den = (m > UNIT) ? m : UNIT;
                cmd.left_value = scale_cmd(l, full, den);
                cmd.right_value = scale_cmd(r, full, den);
                cmd.is_voltage = (func == FUNC_VEC_VOLT);
            end
            FUNC_TANK: begin
                // Strict deadband: a speed equal to the threshold survives.
                if (mag(a) < dz) a = 0;
                if (mag(b) < dz) b = 0;
                cmd.left_value = scale_cmd(a, max_volt, UNIT);
                cmd.right_value = scale_cmd(b, max_volt, UNIT);
                cmd.is_voltage = 1'b1;
            end
            FUNC_ARCADE: begin
                // Inclusive deadband, then quadrant mixing on the sign of a and b.
                if (mag(a) <= dz) a = 0;
                if (mag(b) <= dz) b = 0;
                mx = (mag(a) > mag(b)) ? mag(a) : mag(b);
                if (a < 0) mx = -mx;
                if ((a >= 0) == (b >= 0)) begin
                    l = mx;
                    r = a - b;
                end else begin
                    l = a + b;
                    r = mx;
                end
                cmd.left_value = scale_cmd(clip_unit(l), max_volt, UNIT);
                cmd.right_value = scale_cmd(clip_unit(r), max_volt, UNIT);
                cmd.is_voltage = 1'b1;
            end
            FUNC_LEFT: begin
                cmd.left_value = scale_cmd(a, max_vel, UNIT);
                cmd.right_valid = 1'b0;
            end
            FUNC_RIGHT: begin
                cmd.right_value = scale_cmd(a, max_vel, UNIT);
                cmd.left_valid = 1'b0;
            end
            default: begin
                cmd.left_valid = 1'b0;
                cmd.right_valid = 1'b0;
            end
        endcase
        return cmd;
    endfunction

    // Output check first, then register writes, then new predictions.
    always @(posedge i_clk) begin
        motor_cmd_t want;
        motor_cmd_t got;
        if (!i_rst_n) begin
            max_vel = MAX_VEL_RST;
            max_volt = MAX_VOLT_RST;
            deadband = DEADBAND_RST;
            motor_cmd_queue.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.left_value = m_axis_tdata[OUT_W-1:0];
                got.right_value = m_axis_tdata[2*OUT_W-1:OUT_W];
                got.left_valid = m_axis_tuser[0];
                got.right_valid = m_axis_tuser[1];
                got.is_voltage = m_axis_tuser[2];
                if (motor_cmd_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%t: output transaction with no command pending: L=%0d R=%0d",
                                 $realtime, $signed(got.left_value),
                                 $signed(got.right_value));
                end else begin
                    want = motor_cmd_queue.pop_front();
                    if (got.left_value !== want.left_value ||
                        got.right_value !== want.right_value ||
                        got.left_valid !== want.left_valid ||
                        got.right_valid !== want.right_valid ||
                        got.is_voltage !== want.is_voltage) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%t: motor command mismatch: expected L=%0d R=%0d lv=%0b rv=%0b volt=%0b",
                                     $realtime, $signed(want.left_value),
                                     $signed(want.right_value), want.left_valid,
                                     want.right_valid, want.is_voltage);
                            $display("    got L=%0d R=%0d lv=%0b rv=%0b volt=%0b",
                                     $signed(got.left_value), $signed(got.right_value),
                                     got.left_valid, got.right_valid, got.is_voltage);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_VEL:  max_vel = i_cfg_data;
                    CFG_MAX_VOLT: max_volt = i_cfg_data;
                    CFG_DEADBAND: deadband = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                motor_cmd_queue.push_back(mix_motor_cmds(s_axis_tuser,
                                                         s_axis_tdata[SPEED_W-1:0],
                                                         s_axis_tdata[2*SPEED_W-1:SPEED_W]));
        end
        o_pending <= motor_cmd_queue.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: dv/tb_differential_drive_mixer.sv
`timescale 1ns / 100ps

// Drives speed commands and register writes into the drive mixer under
// several idle and backpressure patterns; the checker does the comparing.
module tb_differential_drive_mixer;
    import dmix_pkg::*;

    localparam int UNIT         = 16384;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS  = 190;
    localparam int NUM_PHASES   = 8;
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;
    // Lowest and highest undefined drive modes.
    localparam logic [FUNC_W-1:0] FUNC_BAD_LO = 4'd9;
    localparam logic [FUNC_W-1:0] FUNC_BAD_HI = 4'd15;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata = '0;   // speed_a[16:0], speed_b[33:17], zero pad
    logic [FUNC_W-1:0]    s_axis_tuser = '0;   // func[3:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [2*OUT_W-1:0]   m_axis_tdata;        // left_value[15:0], right_value[31:16]
    logic [2:0]           m_axis_tuser;        // left_valid[0], right_valid[1], is_voltage[2]
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    int pending;
    int fail_count;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int db_now = 0;

    // Register settings per random phase; a negative entry means a random value.
    int vel_tab[NUM_PHASES]  = '{32767, 0, 1, -1, 200, -1, 32767, -1};
    int volt_tab[NUM_PHASES] = '{32767, 0, 1, -1, 12000, -1, 1, -1};
    int db_tab[NUM_PHASES]   = '{16384, 0, 1, -1, 16384, -1, 0, -1};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    differential_drive_mixer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    drive_mix_checker mix_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // Output backpressure at the rate of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: ends the run when no channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sends one speed command; before it the sender idles in each cycle at the
    // idle rate of the current phase.
    task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [SPEED_W-1:0] spd_a,
                            input logic [SPEED_W-1:0] spd_b);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {6'b0, spd_b, spd_a};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Holds off input until every pending command has come out, then lets
    // the pipeline settle.
    task automatic drain_mixer();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three registers back to back, optionally poking the unused index.
    task automatic program_regs(input int vel, input int volt, input int db,
                                input bit poke_unused);
        logic [IDX_W-1:0] idx[4];
        logic [CFG_W-1:0] val[4];
        int               count;
        idx = '{CFG_MAX_VEL, CFG_MAX_VOLT, CFG_DEADBAND, CFG_UNUSED};
        val = '{vel[CFG_W-1:0], volt[CFG_W-1:0], db[CFG_W-1:0], 15'h7fff};
        count = poke_unused ? 4 : 3;
        db_now = db;
        for (int k = 0; k < count; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Random speed biased toward the clamp edges, the deadband and the extremes.
    function automatic logic [SPEED_W-1:0] pick_speed(input int db);
        int v;
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2: begin
                v = $urandom_range(131071);
                v = v - 65536;
            end
            3, 4: begin
                v = $urandom_range(2 * UNIT);
                v = v - UNIT;
            end
            5: v = UNIT - 2 + $urandom_range(4);
            6: v = db - 1 + $urandom_range(2);
            7: begin
                pick = $urandom_range(3);
                v = (pick == 0) ? -65536 : (pick == 1) ? 65535 : (pick == 2) ? 0 : -1;
            end
            default: begin
                v = $urandom_range(2000);
                v = v - 1000;
            end
        endcase
        if (pick >= 5 && pick <= 6 && $urandom_range(1) == 1) v = -v;
        return v[SPEED_W-1:0];
    endfunction

    initial begin
        int vel, volt, db;
        logic [FUNC_W-1:0] func;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every mode at the reset register values, with the field extremes.
        send_cmd(FUNC_STOP, 17'sd5000, -17'sd5000);
        send_cmd(FUNC_FORWARD, 17'sd65535, 17'sd0);
        send_cmd(FUNC_ROTATE, -17'sd65536, 17'sd65535);
        send_cmd(FUNC_VEC_VEL, 17'sd16384, 17'sd16384);
        send_cmd(FUNC_VEC_VOLT, 17'sd16384, 17'sd0);
        send_cmd(FUNC_VEC_VOLT, -17'sd65536, 17'sd65535);
        send_cmd(FUNC_TANK, -17'sd16384, 17'sd16383);
        send_cmd(FUNC_ARCADE, 17'sd0, 17'sd0);
        send_cmd(FUNC_ARCADE, -17'sd1, -17'sd1);
        send_cmd(FUNC_LEFT, -17'sd16385, 17'sd300);
        send_cmd(FUNC_RIGHT, 17'sd12345, -17'sd300);
        send_cmd(FUNC_BAD_LO, 17'sd65535, -17'sd65536);
        send_cmd(FUNC_BAD_HI, -17'sd1, 17'sd1);
        drain_mixer();

        // Deadband edges and the arcade quadrants at full scale.
        program_regs(32767, 32767, 1000, 1'b0);
        send_cmd(FUNC_TANK, 17'sd1000, -17'sd999);
        send_cmd(FUNC_ARCADE, 17'sd1000, -17'sd1001);
        send_cmd(FUNC_ARCADE, 17'sd5000, 17'sd3000);
        send_cmd(FUNC_ARCADE, 17'sd5000, -17'sd3000);
        send_cmd(FUNC_ARCADE, -17'sd5000, 17'sd3000);
        send_cmd(FUNC_ARCADE, -17'sd5000, -17'sd3000);
        send_cmd(FUNC_ARCADE, 17'sd16384, -17'sd16384);
        send_cmd(FUNC_ARCADE, -17'sd16384, -17'sd16384);
        send_cmd(FUNC_VEC_VEL, -17'sd16384, 17'sd16384);

        // Random phases, each with its own register setting and idle pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_mixer();
            vel = (vel_tab[p] < 0) ? $urandom_range(32767) : vel_tab[p];
            volt = (volt_tab[p] < 0) ? $urandom_range(32767) : volt_tab[p];
            db = (db_tab[p] < 0) ? $urandom_range(UNIT) : db_tab[p];
            program_regs(vel, volt, db, p == 3);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && p % 2 == 1) drain_mixer();
                func = ($urandom_range(99) < 8) ?
                       FUNC_W'($urandom_range(FUNC_BAD_HI, FUNC_BAD_LO)) :
                       FUNC_W'($urandom_range(FUNC_RIGHT));
                send_cmd(func, pick_speed(db_now), pick_speed(db_now));
            end
        end

        drain_mixer();
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
